// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, off while reset is high.
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk_sig, rst_sig, cond, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) !(cond)) \
    else $error(msg);

`endif

// File: design/spb_pkg.sv
// ----------------------------------------------------------------------------
// spb_pkg
// Types, codes and helpers for the sprite pixel blender.
// ----------------------------------------------------------------------------
package spb_pkg;

  localparam int unsigned PIPE_DEPTH = 5;

  typedef enum logic [1:0] {
    MODE_MASK   = 2'd0,
    MODE_SPRITE = 2'd1,
    MODE_LEGACY = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_BLEND_MODE = 2'd0,
    REG_FADE_ALPHA = 2'd1,
    REG_MASK_COLOR = 2'd2
  } reg_idx_t;

  // Control that travels with each item down the pipe.
  typedef struct packed {
    logic vld;
    logic we;
    logic legacy;
    logic copy;
  } ctl_t;

  // floor(x/255) for x < 65280 via reciprocal approximation with correction.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + 17'(x[15:8]) + 17'd1;
    return sum[15:8];
  endfunction

endpackage

// File: design/sprite_pixel_blender_unit.sv
// ----------------------------------------------------------------------------
// sprite_pixel_blender_unit
// ARGB8888 blender: mask color, sprite alpha and legacy saturating modes.
// ----------------------------------------------------------------------------
// Pipeline: done is raised when the started item leaves the last stage.
// Throughput: one item per cycle; busy is always low, the result is never stalled.
// The pipe has five stages: alpha scale, alpha divide, per-channel
// multiplies, channel sum, divide by 255 and assembly.
// Reset (rst, synchronous): clears all stage valids, loads mode 1, global
// alpha 255 and mask color 0xFFFFFF. The config channel is always ready.
`include "assert_macros.svh"

module sprite_pixel_blender_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] src_pixel,
  input  logic [7:0]  mask_alpha,
  input  logic [31:0] dst_pixel,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  spb_pkg::reg_idx_t cfg_index,
  input  logic [23:0] cfg_data,
  output logic        done,
  output logic        write_enable,
  output logic [31:0] result_pixel
);
  import spb_pkg::*;

  mode_t       blend_mode;
  logic [7:0]  fade_alpha;
  logic [23:0] mask_color;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= MODE_SPRITE;
      fade_alpha <= 8'hFF;
      mask_color <= 24'hFFFFFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BLEND_MODE: blend_mode <= mode_t'(cfg_data[1:0]);
        REG_FADE_ALPHA: fade_alpha <= cfg_data[7:0];
        REG_MASK_COLOR: mask_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- stage A: capture, write decision, alpha product
  logic        acc;
  logic        a_vld, a_we;
  mode_t       a_mode;
  logic [31:0] a_src, a_dst;
  logic [7:0]  a_mask;
  logic [15:0] a_prod;
  logic        we_in;

  assign acc = start && !busy;

  always_comb begin
    case (blend_mode)
      MODE_MASK:   we_in = (mask_alpha != 8'd0);
      MODE_SPRITE: we_in = (fade_alpha != 8'd0) && (src_pixel[31:24] != 8'd0);
      MODE_LEGACY: we_in = (src_pixel[31:24] != 8'd0);
      default:     we_in = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else     a_vld <= acc;
  end

  always_ff @(posedge clk) begin
    a_we   <= we_in;
    a_mode <= blend_mode;
    a_src  <= src_pixel;
    a_dst  <= dst_pixel;
    a_mask <= mask_alpha;
    a_prod <= 16'(src_pixel[31:24]) * 16'(fade_alpha);
  end

  // ---------------- stage B: effective alpha, source color select
  ctl_t             b_ctl;
  logic [7:0]       b_alpha;
  logic [2:0][7:0]  b_s;
  logic [31:0]      b_src, b_dst;
  logic [7:0]       alpha_a;

  assign alpha_a = (a_mode == MODE_MASK) ? a_mask : div255(a_prod);

  always_ff @(posedge clk) begin
    if (rst) b_ctl.vld <= 1'b0;
    else     b_ctl.vld <= a_vld;
    b_ctl.we     <= a_we;
    b_ctl.legacy <= (a_mode == MODE_LEGACY);
    b_ctl.copy   <= (a_mode == MODE_SPRITE) && (alpha_a == 8'hFF);
    b_alpha      <= alpha_a;
    b_s          <= (a_mode == MODE_MASK) ? mask_color : a_src[23:0];
    b_src        <= a_src;
    b_dst        <= a_dst;
  end

  // ---------------- stage C: per-channel products
  ctl_t              c_ctl;
  logic [2:0][15:0]  c_p1, c_p2;
  logic [2:0][7:0]   c_s;
  logic [31:0]       c_src, c_dst;
  logic [7:0]        inv_alpha;

  assign inv_alpha = 8'hFF - b_alpha;

  always_ff @(posedge clk) begin
    if (rst) c_ctl.vld <= 1'b0;
    else     c_ctl.vld <= b_ctl.vld;
    c_ctl.we     <= b_ctl.we;
    c_ctl.legacy <= b_ctl.legacy;
    c_ctl.copy   <= b_ctl.copy;
    c_s          <= b_s;
    c_src        <= b_src;
    c_dst        <= b_dst;
    for (int i = 0; i < 3; i++) begin
      if (b_ctl.legacy) begin
        c_p1[i] <= 16'd0;
        c_p2[i] <= 16'(8'hFF - b_s[i]) * 16'(b_dst[8*i +: 8]);
      end else begin
        c_p1[i] <= 16'(b_s[i]) * 16'(b_alpha);
        c_p2[i] <= 16'(b_dst[8*i +: 8]) * 16'(inv_alpha);
      end
    end
  end

  // ---------------- stage D: channel sums (legacy adds rounding bias)
  ctl_t              d_ctl;
  logic [2:0][15:0]  d_num;
  logic [2:0][7:0]   d_s;
  logic [31:0]       d_src, d_dst;

  always_ff @(posedge clk) begin
    if (rst) d_ctl.vld <= 1'b0;
    else     d_ctl.vld <= c_ctl.vld;
    d_ctl.we     <= c_ctl.we;
    d_ctl.legacy <= c_ctl.legacy;
    d_ctl.copy   <= c_ctl.copy;
    d_s          <= c_s;
    d_src        <= c_src;
    d_dst        <= c_dst;
    for (int i = 0; i < 3; i++) begin
      d_num[i] <= c_p1[i] + c_p2[i] + (c_ctl.legacy ? 16'd127 : 16'd0);
    end
  end

  // ---------------- stage E: divide, legacy add, result assembly
  logic [2:0][7:0] chan_e;
  logic [31:0]     pixel_e;

  always_comb begin
    logic [7:0] q;
    logic [8:0] sum;
    for (int i = 0; i < 3; i++) begin
      q   = div255(d_num[i]);
      sum = {1'b0, d_s[i]} + {1'b0, q};
      if (d_ctl.legacy) chan_e[i] = sum[8] ? 8'hFF : sum[7:0];
      else              chan_e[i] = q;
    end
    if (!d_ctl.we)       pixel_e = d_dst;
    else if (d_ctl.copy) pixel_e = d_src;
    else                 pixel_e = {8'hFF, chan_e};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done         <= 1'b0;
      write_enable <= 1'b0;
    end else begin
      done         <= d_ctl.vld;
      write_enable <= d_ctl.vld && d_ctl.we;
    end
  end

  always_ff @(posedge clk) begin
    result_pixel <= pixel_e;
  end

  // ---------------- checks
  `ASSERT_CLK(a_done_follows_start, clk, rst, done |-> $past(start, PIPE_DEPTH),
    "done without a start PIPE_DEPTH cycles earlier")
  `ASSERT_CLK(a_nowrite_keeps_dst, clk, rst,
    (done && !write_enable) |-> (result_pixel == $past(dst_pixel, PIPE_DEPTH)),
    "no-write item does not return the destination pixel")
  `ASSERT_NEVER(a_we_without_done, clk, rst, write_enable && !done,
    "write_enable raised outside a done strobe")

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the sprite pixel blender against a cycle-free model of its
// three blend modes, driving random and corner-case pixels through phases
// of varying sender gaps and register settings.
// ----------------------------------------------------------------------------
module testbench;
  import spb_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned QUIET_CYCLES = PIPE_DEPTH + 2;

  typedef enum logic [1:0] {JOB_PIXEL, JOB_REG, JOB_SETTLE} job_kind_t;

  typedef struct {
    job_kind_t   kind;
    logic [31:0] src;
    logic [7:0]  mask;
    logic [31:0] dst;
    logic [1:0]  reg_idx;
    logic [23:0] reg_val;
    int unsigned gap_pct;
  } blend_job_t;

  typedef struct packed {
    logic        we;
    logic [31:0] pix;
  } blend_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] src_pixel = '0;
  logic [7:0]  mask_alpha = '0;
  logic [31:0] dst_pixel = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  reg_idx_t    cfg_index = REG_BLEND_MODE;
  logic [23:0] cfg_data = '0;
  logic        done;
  logic        write_enable;
  logic [31:0] result_pixel;

  blend_job_t  job_q[$];
  blend_out_t  blend_q[$];
  logic        pix_taken = 1'b0;
  logic        reg_taken = 1'b0;
  logic        feed_done = 1'b0;
  int unsigned quiet_cnt = 0;
  int          err_cnt = 0;

  // model copy of the registers
  logic [1:0]  cur_mode = MODE_SPRITE;
  logic [7:0]  cur_ga = 8'hFF;
  logic [23:0] cur_color = 24'hFFFFFF;

  sprite_pixel_blender_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .src_pixel    (src_pixel),
    .mask_alpha   (mask_alpha),
    .dst_pixel    (dst_pixel),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .write_enable (write_enable),
    .result_pixel (result_pixel)
  );

  always #1 clk = ~clk;

  function automatic logic [31:0] lerp_rgb(logic [23:0] s, logic [31:0] d, logic [7:0] a);
    logic [31:0] out;
    int unsigned sc, dc, v;
    out = 32'hFF000000;
    for (int k = 0; k < 3; k++) begin
      sc = s[8*k +: 8];
      dc = d[8*k +: 8];
      v = (sc * a + dc * (255 - a)) / 255;
      out[8*k +: 8] = v[7:0];
    end
    return out;
  endfunction

  function automatic logic [31:0] screen_rgb(logic [31:0] s, logic [31:0] d);
    logic [31:0] out;
    int unsigned sc, dc, v;
    out = 32'hFF000000;
    for (int k = 0; k < 3; k++) begin
      sc = s[8*k +: 8];
      dc = d[8*k +: 8];
      v = sc + ((255 - sc) * dc + 127) / 255;
      if (v > 255) v = 255;
      out[8*k +: 8] = v[7:0];
    end
    return out;
  endfunction

  function automatic blend_out_t predict_blend(logic [31:0] src, logic [7:0] mask,
                                               logic [31:0] dst);
    blend_out_t  r;
    int unsigned sa, a;
    sa = src[31:24];
    r.we = 1'b0;
    r.pix = dst;
    case (cur_mode)
      MODE_MASK: begin
        if (mask != 0) begin
          r.we = 1'b1;
          r.pix = lerp_rgb(cur_color, dst, mask);
        end
      end
      MODE_SPRITE: begin
        if (cur_ga != 0 && sa != 0) begin
          a = (sa * cur_ga) / 255;
          r.we = 1'b1;
          r.pix = (a == 255) ? src : lerp_rgb(src[23:0], dst, a[7:0]);
        end
      end
      MODE_LEGACY: begin
        if (sa != 0) begin
          r.we = 1'b1;
          r.pix = screen_rgb(src, dst);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // sample results and accepted items at the rising edge
  always @(posedge clk) begin : monitor
    blend_out_t want;
    if (rst) begin
      cur_mode = MODE_SPRITE;
      cur_ga = 8'hFF;
      cur_color = 24'hFFFFFF;
      pix_taken <= 1'b0;
      reg_taken <= 1'b0;
    end else begin
      if (done) begin
        if (blend_q.size() == 0) begin
          $error("result with no item pending: we=%0b pix=%08h", write_enable, result_pixel);
          err_cnt++;
        end else begin
          want = blend_q.pop_front();
          if (write_enable !== want.we) begin
            $error("write_enable: expected %0b, got %0b", want.we, write_enable);
            err_cnt++;
          end
          if (result_pixel !== want.pix) begin
            $error("result_pixel: expected %08h, got %08h", want.pix, result_pixel);
            err_cnt++;
          end
        end
      end
      if (start && !busy) blend_q.push_back(predict_blend(src_pixel, mask_alpha, dst_pixel));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BLEND_MODE: cur_mode = cfg_data[1:0];
          REG_FADE_ALPHA: cur_ga = cfg_data[7:0];
          REG_MASK_COLOR: cur_color = cfg_data;
          default: ;
        endcase
      end
      pix_taken <= start && !busy;
      reg_taken <= cfg_valid && cfg_ready;
    end
  end

  // drive the next item or register write at the falling edge
  always @(negedge clk) begin : driver
    blend_job_t job;
    logic       drive_pix, drive_reg, quiet;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      quiet_cnt = 0;
    end else begin
      drive_pix = start && !pix_taken;
      drive_reg = cfg_valid && !reg_taken;
      if (!drive_pix && !drive_reg) begin
        quiet_cnt = (blend_q.size() == 0) ? quiet_cnt + 1 : 0;
        quiet = quiet_cnt >= QUIET_CYCLES;
        if (job_q.size() == 0) begin
          feed_done <= 1'b1;
        end else begin
          case (job_q[0].kind)
            JOB_PIXEL: begin
              if ($urandom_range(99) >= job_q[0].gap_pct) begin
                job = job_q.pop_front();
                drive_pix = 1'b1;
                src_pixel <= job.src;
                mask_alpha <= job.mask;
                dst_pixel <= job.dst;
              end
            end
            JOB_REG: begin
              if (quiet) begin
                job = job_q.pop_front();
                drive_reg = 1'b1;
                cfg_index <= reg_idx_t'(job.reg_idx);
                cfg_data <= job.reg_val;
              end
            end
            default: begin
              if (quiet) job = job_q.pop_front();
            end
          endcase
        end
      end
      start <= drive_pix;
      cfg_valid <= drive_reg;
    end
  end

  task automatic add_pixel(logic [31:0] src, logic [7:0] mask, logic [31:0] dst,
                           int unsigned gap);
    blend_job_t j;
    j = '{kind: JOB_PIXEL, src: src, mask: mask, dst: dst, reg_idx: '0, reg_val: '0,
          gap_pct: gap};
    job_q.push_back(j);
  endtask

  task automatic add_reg(logic [1:0] idx, logic [23:0] val);
    blend_job_t j;
    j = '{kind: JOB_REG, src: '0, mask: '0, dst: '0, reg_idx: idx, reg_val: val,
          gap_pct: 0};
    job_q.push_back(j);
  endtask

  task automatic add_settle();
    blend_job_t j;
    j = '{kind: JOB_SETTLE, src: '0, mask: '0, dst: '0, reg_idx: '0, reg_val: '0,
          gap_pct: 0};
    job_q.push_back(j);
  endtask

  // new random register set, extremes weighted up; upper data bits are noise
  task automatic shuffle_settings();
    logic [1:0]  mode;
    logic [7:0]  ga;
    logic [23:0] color;
    int unsigned r;
    r = $urandom_range(9);
    mode = (r < 3) ? MODE_MASK : (r < 6) ? MODE_SPRITE : (r < 9) ? MODE_LEGACY : MODE_UNUSED;
    case ($urandom_range(5))
      0: ga = 8'h00;
      1: ga = 8'hFF;
      2: ga = 8'h01;
      default: ga = 8'($urandom);
    endcase
    case ($urandom_range(3))
      0: color = 24'h000000;
      1: color = 24'hFFFFFF;
      default: color = 24'($urandom);
    endcase
    add_reg(REG_BLEND_MODE, {22'($urandom), mode});
    add_reg(REG_FADE_ALPHA, {16'($urandom), ga});
    add_reg(REG_MASK_COLOR, color);
  endtask

  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int unsigned gaps[3] = '{20, 77, 0};
    // sprite mode at reset settings
    add_pixel(32'h00FFFFFF, 8'hFF, 32'h12345678, 0);
    add_pixel(32'hFF123456, 8'h00, 32'hFFFFFFFF, 0);
    add_pixel(32'h80FFFFFF, 8'h00, 32'h00000000, 0);
    add_pixel(32'h7F000000, 8'hFF, 32'hFFFFFFFF, 0);
    add_pixel(32'h01FFFFFF, 8'h00, 32'h00000000, 0);
    // global alpha zero blocks writes; tiny alpha scales to zero but still writes
    add_reg(REG_FADE_ALPHA, 24'h000000);
    add_pixel(32'hFFFFFFFF, 8'hFF, 32'h00000000, 0);
    add_reg(REG_FADE_ALPHA, 24'h000001);
    add_pixel(32'hFEFFFFFF, 8'h80, 32'h00ABCDEF, 0);
    add_pixel(32'hFFFFFFFF, 8'h00, 32'h00000000, 0);
    add_reg(REG_FADE_ALPHA, 24'h000080);
    add_pixel(32'hFF00FF00, 8'h00, 32'hFFFF00FF, 0);
    // mask mode
    add_reg(REG_BLEND_MODE, 24'(MODE_MASK));
    add_reg(REG_MASK_COLOR, 24'h123456);
    add_pixel(32'hFFFFFFFF, 8'h00, 32'h89ABCDEF, 0);
    add_pixel(32'h00000000, 8'hFF, 32'h89ABCDEF, 0);
    add_pixel(32'h00000000, 8'h01, 32'hFFFFFFFF, 0);
    add_pixel(32'hFFFFFFFF, 8'h80, 32'h00000000, 0);
    add_reg(REG_MASK_COLOR, 24'h000000);
    add_pixel(32'h00000000, 8'hFF, 32'hFFFFFFFF, 0);
    // legacy saturating mode
    add_reg(REG_BLEND_MODE, 24'(MODE_LEGACY));
    add_pixel(32'h00FFFFFF, 8'hFF, 32'h12345678, 0);
    add_pixel(32'hFFFFFFFF, 8'h00, 32'h00000000, 0);
    add_pixel(32'h01000000, 8'h00, 32'hFFFFFFFF, 0);
    add_pixel(32'h80804020, 8'h00, 32'h7F3F1F0F, 0);
    // unused mode, then a write to an unmapped index that must be ignored
    add_reg(REG_BLEND_MODE, 24'hFFFFFF);
    add_pixel(32'hFFFFFFFF, 8'hFF, 32'h00000000, 0);
    add_reg(REG_UNUSED, 24'h000001);
    add_pixel(32'h80808080, 8'h80, 32'h40404040, 0);

    foreach (gaps[p]) begin
      for (int b = 0; b < 4; b++) begin
        shuffle_settings();
        for (int i = 0; i < 40; i++) begin
          if (i == 20) add_settle();
          add_pixel({pick_alpha(), 24'($urandom)}, pick_alpha(), $urandom, gaps[p]);
        end
      end
    end
  end

  initial begin : run_ctrl
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait (feed_done);
    for (int n = 0; n < 1000 && blend_q.size() != 0; n++) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (blend_q.size() != 0) begin
      $error("%0d results never arrived", blend_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("status: fail");
    $finish;
  end

endmodule
